// ===== design/addressable_led_serializer_defines.svh =====
// Assertion macros shared by the LED serializer modules.
`ifndef ADDRESSABLE_LED_SERIALIZER_DEFINES_SVH
`define ADDRESSABLE_LED_SERIALIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LEDSER_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LEDSER_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ledser_pkg.sv =====
// Types, codes and helpers shared by the LED serializer modules.
package ledser_pkg;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_REFRESH = 2'd1;
    localparam logic [1:0] CMD_BIT     = 2'd2;

    localparam logic [2:0] CFG_FRAME_PERIOD = 3'd0;
    localparam logic [2:0] CFG_SEND_PHASE   = 3'd1;
    localparam logic [2:0] CFG_LEAD_TICKS   = 3'd2;
    localparam logic [2:0] CFG_DATA_TICKS   = 3'd3;
    localparam logic [2:0] CFG_TAIL_TICKS   = 3'd4;

    localparam logic [7:0] RST_FRAME_PERIOD = 8'd60;
    localparam logic [7:0] RST_SEND_PHASE   = 8'd50;
    localparam logic [5:0] RST_LEAD_TICKS   = 6'd8;
    localparam logic [5:0] RST_DATA_TICKS   = 6'd12;
    localparam logic [5:0] RST_TAIL_TICKS   = 6'd2;

    localparam logic [1:0] PH_LEAD = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_TAIL = 2'd2;

    localparam logic [2:0] LAST_BIT  = 3'd7;
    localparam logic [1:0] LAST_BYTE = 2'd2;
    localparam logic [1:0] LAST_SLOT = 2'd2;

    typedef struct packed {
        logic [7:0] frame_period;
        logic [7:0] send_phase;
        logic [5:0] lead_ticks;
        logic [5:0] data_ticks;
        logic [5:0] tail_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] value;
        logic [1:0] channel;
        logic [5:0] led_index;
    } item_t;

    typedef struct packed {
        logic refused;
        logic busy_res;
        logic line;
    } res_t;

    // Color slot sent at each byte position of an LED.
    function automatic logic [1:0] send_slot(input logic [1:0] pos);
        logic [1:0] slot;
        case (pos)
            2'd0:    slot = 2'd1;
            2'd1:    slot = 2'd0;
            default: slot = 2'd2;
        endcase
        return slot;
    endfunction

    // Ticks spent in a bit phase; a zero setting lasts one tick.
    function automatic logic [5:0] phase_len(input logic [1:0] ph, input cfg_t cfg);
        logic [5:0] n;
        case (ph)
            PH_LEAD: n = cfg.lead_ticks;
            PH_DATA: n = cfg.data_ticks;
            default: n = cfg.tail_ticks;
        endcase
        return (n == 6'd0) ? 6'd1 : n;
    endfunction

endpackage

// ===== design/ledser_store.sv =====
// Color byte memory: one write port, one registered read port.
module ledser_store #(
    parameter int DEPTH = 192,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ledser_mod.sv =====
// Restoring remainder unit: dividend mod divisor, one bit per cycle.
module ledser_mod import ledser_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] dividend,
    input  logic [7:0] divisor,
    output logic       busy,
    output logic       done,
    output logic [7:0] rem
);

    logic       busy_reg;
    logic       done_reg;
    logic [2:0] step_reg;
    logic [7:0] dq_reg;
    logic [7:0] rem_reg;
    logic [7:0] div_reg;
    logic [8:0] trial;
    logic       fits;
    logic [7:0] rem_step;

    assign trial    = {rem_reg, dq_reg[7]};
    assign fits     = trial >= {1'b0, div_reg};
    assign rem_step = fits ? 8'(trial - {1'b0, div_reg}) : trial[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 3'd1;
            if (step_reg == LAST_BIT)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= 8'd0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[6:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    // Hold off items until the result has been loaded by the core.
    assign busy = busy_reg || done_reg;
    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== design/ledser_core.sv =====
// Frame sequencer: refresh counter, bit timing and pixel fetch addressing.
`include "addressable_led_serializer_defines.svh"
module ledser_core import ledser_pkg::*; #(
    parameter int LED_COUNT = 64,
    parameter int LW        = 6,
    parameter int AW        = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  item_t         item,
    input  cfg_t          cfg,
    input  logic          mod_busy,
    input  logic          mod_done,
    input  logic [7:0]    mod_rem,
    input  logic [7:0]    mem_rd_data,
    output logic          mem_wr_en,
    output logic [AW-1:0] mem_wr_addr,
    output logic [7:0]    mem_wr_data,
    output logic [AW-1:0] mem_rd_addr,
    output logic [7:0]    count,
    output res_t          res
);

    localparam int CW   = (AW > 8) ? AW : 8;
    localparam int CMPW = ($clog2(LED_COUNT + 1) > 6) ? $clog2(LED_COUNT + 1) : 6;

    logic [7:0]    count_reg, count_next;
    logic [7:0]    count_mod_reg, count_mod_next;
    logic          sending_reg, sending_next;
    logic [LW-1:0] led_pos_reg, led_pos_next;
    logic [1:0]    byte_pos_reg, byte_pos_next;
    logic [2:0]    bit_pos_reg, bit_pos_next;
    logic [1:0]    bit_phase_reg, bit_phase_next;
    logic [5:0]    phase_ticks_reg, phase_ticks_next;
    logic          line_reg, line_next;

    logic [7:0] cnt1;
    logic [7:0] mod1;
    logic [5:0] pt1;
    logic [5:0] len;
    logic       data_bit;
    logic       led_ok;
    logic [CW-1:0] wr_addr_wide;

    assign cnt1     = count_reg + 8'd1;
    assign mod1     = count_mod_reg + 8'd1;
    assign pt1      = phase_ticks_reg + 6'd1;
    assign len      = phase_len(bit_phase_reg, cfg);
    assign data_bit = mem_rd_data[LAST_BIT - bit_pos_reg];
    assign led_ok   = CMPW'(item.led_index) < CMPW'(LED_COUNT);

    assign wr_addr_wide = CW'(item.led_index) + CW'({item.led_index, 1'b0})
                          + CW'(item.channel);
    assign mem_wr_addr  = wr_addr_wide[AW-1:0];
    assign mem_wr_data  = item.value;
    // Fetch the byte for the position the sequencer moves to.
    assign mem_rd_addr  = AW'(led_pos_next) + AW'({led_pos_next, 1'b0})
                          + AW'(send_slot(byte_pos_next));

    always_comb
    begin
        count_next       = count_reg;
        count_mod_next   = mod_done ? mod_rem : count_mod_reg;
        sending_next     = sending_reg;
        led_pos_next     = led_pos_reg;
        byte_pos_next    = byte_pos_reg;
        bit_pos_next     = bit_pos_reg;
        bit_phase_next   = bit_phase_reg;
        phase_ticks_next = phase_ticks_reg;
        line_next        = line_reg;
        mem_wr_en        = 1'b0;
        res.refused      = 1'b0;

        if (fire)
        begin
            case (item.command)
                CMD_WRITE:
                begin
                    if (sending_reg)
                    begin
                        res.refused = 1'b1;
                    end
                    else if (led_ok && item.channel <= LAST_SLOT)
                    begin
                        mem_wr_en = 1'b1;
                    end
                end
                CMD_REFRESH:
                begin
                    if (!sending_reg)
                    begin
                        if (cnt1 == 8'd1)
                        begin
                            line_next = 1'b0;
                        end
                        if ({1'b0, cnt1} == ({1'b0, cfg.send_phase} + 9'd1))
                        begin
                            line_next = 1'b0;
                        end
                        if (cnt1 == cfg.send_phase)
                        begin
                            sending_next     = 1'b1;
                            led_pos_next     = '0;
                            byte_pos_next    = 2'd0;
                            bit_pos_next     = 3'd0;
                            bit_phase_next   = PH_LEAD;
                            phase_ticks_next = 6'd0;
                        end
                        // Remainder tracked separately so the raw count drives the compares.
                        if (cfg.frame_period == 8'd0)
                        begin
                            count_next = cnt1;
                        end
                        else if (cnt1 == 8'd0 || mod1 == cfg.frame_period)
                        begin
                            // A raw count wrapping past 255 also reduces to zero.
                            count_next = 8'd0;
                        end
                        else
                        begin
                            count_next = mod1;
                        end
                        count_mod_next = count_next;
                    end
                end
                CMD_BIT:
                begin
                    if (sending_reg)
                    begin
                        case (bit_phase_reg)
                            PH_LEAD: line_next = 1'b1;
                            PH_DATA: line_next = data_bit;
                            default: line_next = 1'b0;
                        endcase
                        if (pt1 < len)
                        begin
                            phase_ticks_next = pt1;
                        end
                        else
                        begin
                            phase_ticks_next = 6'd0;
                            if (bit_phase_reg < PH_TAIL)
                            begin
                                bit_phase_next = bit_phase_reg + 2'd1;
                            end
                            else
                            begin
                                bit_phase_next = PH_LEAD;
                                bit_pos_next   = bit_pos_reg + 3'd1;
                                if (bit_pos_reg == LAST_BIT)
                                begin
                                    byte_pos_next = byte_pos_reg + 2'd1;
                                    if (byte_pos_reg == LAST_BYTE)
                                    begin
                                        byte_pos_next = 2'd0;
                                        led_pos_next  = led_pos_reg + LW'(1);
                                        if (led_pos_reg == LW'(LED_COUNT - 1))
                                        begin
                                            led_pos_next = '0;
                                            sending_next = 1'b0;
                                            line_next    = 1'b0;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.line     = line_next;
        res.busy_res = sending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= 8'd0;
            count_mod_reg   <= 8'd0;
            sending_reg     <= 1'b0;
            led_pos_reg     <= '0;
            byte_pos_reg    <= 2'd0;
            bit_pos_reg     <= 3'd0;
            bit_phase_reg   <= PH_LEAD;
            phase_ticks_reg <= 6'd0;
            line_reg        <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            count_mod_reg   <= count_mod_next;
            sending_reg     <= sending_next;
            led_pos_reg     <= led_pos_next;
            byte_pos_reg    <= byte_pos_next;
            bit_pos_reg     <= bit_pos_next;
            bit_phase_reg   <= bit_phase_next;
            phase_ticks_reg <= phase_ticks_next;
            line_reg        <= line_next;
        end
    end

    assign count = count_reg;

    `LEDSER_ASSERT_NOW(a_idle_home, !sending_reg,
        led_pos_reg == '0 && byte_pos_reg == 2'd0 && bit_pos_reg == 3'd0,
        "frame position not at start while idle")
    `LEDSER_ASSERT_NOW(a_end_low, $fell(sending_reg), !line_reg,
        "line not low after frame end")
    `LEDSER_ASSERT_NOW(a_mod_range, !mod_busy && cfg.frame_period != 8'd0,
        count_mod_reg < cfg.frame_period,
        "refresh remainder out of range")

endmodule

// ===== design/addressable_led_serializer.sv =====
// Addressable LED chain serializer top level: channels, config and result register.
//
// Items enter on s_tvalid/s_tready: s_tuser carries the command (pixel write,
// refresh tick, bit tick), s_tdata the LED index, color slot and byte. Each beat
// yields exactly one result beat on m_tvalid/m_tready with the line level, the
// frame-busy flag and the write-refused flag after that item.
// Configuration registers are written on cfg_valid/cfg_ready (always ready):
// 0 frame_period, 1 send_phase, 2 lead_ticks, 3 data_ticks, 4 tail_ticks.
// Each input beat goes through the input register, then the result register, to
// its result beat; one item is taken every cycle while the result side keeps up
// and no remainder is running. When m_tready is low the result register holds
// and the input register still takes one more beat; after that s_tready drops
// until the result moves. A nonzero frame_period write starts an 8-step remainder
// of the refresh count, one bit per cycle; s_tready stays low until it is loaded.
// Reset clears the counters, the frame state and the line (low) and loads the
// register defaults; the color store is not cleared and must be written before
// a frame reads it.
`include "addressable_led_serializer_defines.svh"
module addressable_led_serializer import ledser_pkg::*; #(
    parameter int LED_COUNT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // led_index[5:0], channel[7:6], value[15:8]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // line[0], busy_res[1], refused[2], zero[7:3]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int LW    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int DEPTH = LED_COUNT * 3;
    localparam int AW    = $clog2(DEPTH);

    cfg_t  cfg_reg;
    item_t item_reg;
    logic  in_valid_reg;
    logic  out_valid_reg;
    res_t  res_reg;
    res_t  res;

    logic          advance;
    logic          fire;
    logic          cfg_fire;
    logic          mod_start;
    logic          mod_busy;
    logic          mod_done;
    logic [7:0]    mod_rem;
    logic [7:0]    count;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;

    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !mod_busy && (!in_valid_reg || advance);
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign mod_start = cfg_fire && cfg_index == CFG_FRAME_PERIOD && cfg_data != 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_period <= RST_FRAME_PERIOD;
            cfg_reg.send_phase   <= RST_SEND_PHASE;
            cfg_reg.lead_ticks   <= RST_LEAD_TICKS;
            cfg_reg.data_ticks   <= RST_DATA_TICKS;
            cfg_reg.tail_ticks   <= RST_TAIL_TICKS;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_FRAME_PERIOD: cfg_reg.frame_period <= cfg_data;
                CFG_SEND_PHASE:   cfg_reg.send_phase   <= cfg_data;
                CFG_LEAD_TICKS:   cfg_reg.lead_ticks   <= cfg_data[5:0];
                CFG_DATA_TICKS:   cfg_reg.data_ticks   <= cfg_data[5:0];
                CFG_TAIL_TICKS:   cfg_reg.tail_ticks   <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            else if (fire)
            begin
                // Drop a processed item while the input side is held off.
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= {s_tuser, s_tdata[15:8], s_tdata[7:6], s_tdata[5:0]};
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    ledser_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (count),
        .divisor  (cfg_data),
        .busy     (mod_busy),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    ledser_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ledser_core #(
        .LED_COUNT (LED_COUNT),
        .LW        (LW),
        .AW        (AW)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (item_reg),
        .cfg         (cfg_reg),
        .mod_busy    (mod_busy),
        .mod_done    (mod_done),
        .mod_rem     (mod_rem),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .count       (count),
        .res         (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, res_reg};

    `LEDSER_ASSERT_NXT(a_beat_to_result, fire, out_valid_reg,
        "processed beat produced no result")
    `LEDSER_ASSERT_NOW(a_refused_busy, out_valid_reg && res_reg.refused, res_reg.busy_res,
        "write refused outside a frame")

endmodule

// ===== dv/tb.sv =====
// Testbench for the addressable LED chain serializer: stream stimulus and per-beat status check.
`timescale 1ns / 1ps

module tb;
    import ledser_pkg::*;

    localparam int LEDS        = 64;
    localparam int FILL_LEDS   = 8;
    localparam int QUIET_LIMIT = 2000;

    // Everything the chain keeps between items, with its register settings.
    typedef struct {
        logic [0:LEDS*3-1][7:0] colors;
        logic [7:0]             count;
        logic                   busy;
        int                     led;
        int                     byte_sel;
        int                     bit_sel;
        logic [1:0]             phase;
        int                     ph_cnt;
        logic [7:0]             shreg;
        logic                   level;
        cfg_t                   cfg;
    } chain_state_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    item_t        items_todo [$];
    res_t         status_due [$];
    chain_state_t dut_chain;
    chain_state_t plan_chain;
    item_t        on_bus;
    res_t         next_status;
    res_t         want;
    res_t         got;
    logic         was_busy;

    int send_idle_pct   = 0;
    int ready_stall_pct = 0;
    int mismatches      = 0;
    int items_done      = 0;
    int results_seen    = 0;
    int frames_started  = 0;
    int reg_writes      = 0;
    int quiet_cycles    = 0;

    addressable_led_serializer #(.LED_COUNT(LEDS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic chain_state_t fresh_chain();
        chain_state_t c;
        c.colors   = '0;
        c.count    = '0;
        c.busy     = 1'b0;
        c.led      = 0;
        c.byte_sel = 0;
        c.bit_sel  = 0;
        c.phase    = PH_LEAD;
        c.ph_cnt   = 0;
        c.shreg    = '0;
        c.level    = 1'b0;
        c.cfg.frame_period = RST_FRAME_PERIOD;
        c.cfg.send_phase   = RST_SEND_PHASE;
        c.cfg.lead_ticks   = RST_LEAD_TICKS;
        c.cfg.data_ticks   = RST_DATA_TICKS;
        c.cfg.tail_ticks   = RST_TAIL_TICKS;
        return c;
    endfunction

    // Color byte sent at a byte position: slot 1 goes out first, then 0, then 2.
    function automatic logic [7:0] color_at(input chain_state_t c, input int led, input int pos);
        int slot;
        slot = (pos == 0) ? 1 : (pos == 1) ? 0 : 2;
        return c.colors[led * 3 + slot];
    endfunction

    function automatic void load_reg(inout chain_state_t c, input logic [2:0] idx,
                                     input logic [7:0] v);
        case (idx)
            CFG_FRAME_PERIOD: c.cfg.frame_period = v;
            CFG_SEND_PHASE:   c.cfg.send_phase   = v;
            CFG_LEAD_TICKS:   c.cfg.lead_ticks   = v[5:0];
            CFG_DATA_TICKS:   c.cfg.data_ticks   = v[5:0];
            CFG_TAIL_TICKS:   c.cfg.tail_ticks   = v[5:0];
            default: ;
        endcase
    endfunction

    // Advance the chain by one item and return line, busy and refused after it.
    function automatic res_t step_chain(inout chain_state_t c, input item_t it);
        res_t r;
        int   len;
        r = '0;
        case (it.command)
            CMD_WRITE:
            begin
                if (c.busy)
                    r.refused = 1'b1;
                else if (int'(it.led_index) < LEDS && it.channel <= 2'd2)
                    c.colors[int'(it.led_index) * 3 + int'(it.channel)] = it.value;
            end
            CMD_REFRESH:
            begin
                if (!c.busy)
                begin
                    c.count = c.count + 8'd1;
                    if (c.count == 8'd1)
                        c.level = 1'b0;
                    if (int'(c.count) == int'(c.cfg.send_phase) + 1)
                        c.level = 1'b0;
                    if (c.count == c.cfg.send_phase)
                    begin
                        c.busy     = 1'b1;
                        c.led      = 0;
                        c.byte_sel = 0;
                        c.bit_sel  = 0;
                        c.phase    = PH_LEAD;
                        c.ph_cnt   = 0;
                        c.shreg    = color_at(c, 0, 0);
                    end
                    if (c.cfg.frame_period != 8'd0)
                        c.count = c.count % c.cfg.frame_period;
                end
            end
            CMD_BIT:
            begin
                if (c.busy)
                begin
                    case (c.phase)
                        PH_LEAD: c.level = 1'b1;
                        PH_DATA: c.level = c.shreg[7];
                        default: c.level = 1'b0;
                    endcase
                    len = (c.phase == PH_LEAD) ? int'(c.cfg.lead_ticks) :
                          (c.phase == PH_DATA) ? int'(c.cfg.data_ticks) :
                                                 int'(c.cfg.tail_ticks);
                    if (len == 0)
                        len = 1;
                    c.ph_cnt++;
                    if (c.ph_cnt >= len)
                    begin
                        c.ph_cnt = 0;
                        if (c.phase != PH_TAIL)
                            c.phase = c.phase + 2'd1;
                        else
                        begin
                            c.phase = PH_LEAD;
                            c.shreg = c.shreg << 1;
                            c.bit_sel++;
                            if (c.bit_sel == 8)
                            begin
                                c.bit_sel = 0;
                                c.byte_sel++;
                                if (c.byte_sel == 3)
                                begin
                                    c.byte_sel = 0;
                                    c.led++;
                                end
                            end
                            if (c.led == LEDS)
                            begin
                                c.led   = 0;
                                c.busy  = 1'b0;
                                c.level = 1'b0;
                            end
                            else if (c.bit_sel == 0)
                                c.shreg = color_at(c, c.led, c.byte_sel);
                        end
                    end
                end
            end
            default: ;
        endcase
        r.line     = c.level;
        r.busy_res = c.busy;
        return r;
    endfunction

    function automatic item_t make_item(input logic [1:0] cmd, input logic [5:0] led,
                                        input logic [1:0] ch, input logic [7:0] v);
        item_t it;
        it.command   = cmd;
        it.led_index = led;
        it.channel   = ch;
        it.value     = v;
        return it;
    endfunction

    function automatic item_t noise_item();
        return make_item(2'($urandom_range(0, 3)), 6'($urandom), 2'($urandom_range(0, 3)),
                         8'($urandom));
    endfunction

    // Queue an item and move the planning copy along so sequences can follow the frame.
    function automatic void queue_item(input item_t it);
        items_todo.push_back(it);
        void'(step_chain(plan_chain, it));
    endfunction

    // A few writes, refresh ticks up to the frame start, then bit ticks while a frame runs.
    function automatic void frame_session(input int max_refresh, input int max_bits);
        int n;
        int guard;
        logic [1:0] ch;
        n = $urandom_range(0, 6);
        repeat (n)
        begin
            ch = ($urandom_range(0, 15) == 0) ? LAST_SLOT + 2'd1 : 2'($urandom_range(0, 2));
            queue_item(make_item(CMD_WRITE, 6'($urandom), ch, 8'($urandom)));
        end
        guard = 0;
        while (!plan_chain.busy && guard < max_refresh)
        begin
            queue_item(($urandom_range(0, 19) == 0) ? noise_item() :
                       make_item(CMD_REFRESH, 6'($urandom), 2'($urandom), 8'($urandom)));
            guard++;
        end
        guard = 0;
        while (plan_chain.busy && guard < max_bits)
        begin
            queue_item(($urandom_range(0, 19) == 0) ? noise_item() :
                       make_item(CMD_BIT, 6'($urandom), 2'($urandom), 8'($urandom)));
            guard++;
        end
    endfunction

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at result %0d: %s expected %0d got %0d",
                     results_seen, what, want_v, got_v);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge clk);
        load_reg(dut_chain, idx, v);
        load_reg(plan_chain, idx, v);
        reg_writes++;
    endtask

    // Hold off until every queued item is taken and every status beat is back.
    task automatic drain();
        while (items_todo.size() != 0 || s_tvalid || status_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(input logic [7:0] period, input logic [7:0] start_at,
                             input logic [7:0] lead, input logic [7:0] data,
                             input logic [7:0] tail, input int s_pct, input int r_pct,
                             input int sessions, input int max_refresh, input int max_bits);
        write_reg(CFG_FRAME_PERIOD, period);
        write_reg(CFG_SEND_PHASE, start_at);
        write_reg(CFG_LEAD_TICKS, lead);
        write_reg(CFG_DATA_TICKS, data);
        write_reg(CFG_TAIL_TICKS, tail);
        send_idle_pct   = s_pct;
        ready_stall_pct = r_pct;
        for (int k = 0; k < sessions; k++)
        begin
            frame_session(max_refresh, max_bits);
            drain();
        end
    endtask

    // Driver: present the next item once the current beat is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                was_busy    = dut_chain.busy;
                next_status = step_chain(dut_chain, on_bus);
                status_due.push_back(next_status);
                items_done++;
                if (!was_busy && dut_chain.busy)
                    frames_started++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (items_todo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    on_bus = items_todo.pop_front();
                    s_tdata  <= on_bus[15:0];
                    s_tuser  <= on_bus.command;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each status beat against the oldest one due.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got = res_t'(m_tdata[2:0]);
                if (status_due.size() == 0)
                    report_mismatch("status beat with nothing due", 0, 1);
                else
                begin
                    want = status_due.pop_front();
                    if (got.line !== want.line)
                        report_mismatch("line", want.line, got.line);
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", want.busy_res, got.busy_res);
                    if (got.refused !== want.refused)
                        report_mismatch("refused", want.refused, got.refused);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("[addressable_led_serializer] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [7:0] fill;
        dut_chain  = fresh_chain();
        plan_chain = fresh_chain();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Idle chain: bit tick, unused command, write to the missing slot, one refresh.
        queue_item(make_item(CMD_BIT, 6'h3F, 2'd3, 8'hFF));
        queue_item(make_item(CMD_BIT + 2'd1, 6'h2A, 2'd1, 8'h81));
        queue_item(make_item(CMD_WRITE, 6'd5, LAST_SLOT + 2'd1, 8'h5A));
        queue_item(make_item(CMD_REFRESH, 6'd0, 2'd0, 8'd0));

        // Load the first LEDs; a frame never gets past them within this run.
        for (int led = 0; led < FILL_LEDS; led++)
        begin
            for (int ch = 0; ch <= int'(LAST_SLOT); ch++)
            begin
                if (led == 0)
                    fill = (ch == 1) ? 8'hFF : 8'h00;
                else if (led == FILL_LEDS - 1)
                    fill = (ch == 1) ? 8'h00 : 8'hFF;
                else
                    fill = 8'($urandom);
                queue_item(make_item(CMD_WRITE, 6'(led), 2'(ch), fill));
            end
        end
        drain();

        // Count climbs with no wrap, then a short period reduces the raised count.
        run_phase(8'd0,   8'd200, 8'd1,  8'd1,  8'd1,   0,  0, 1, 60, 0);
        run_phase(8'd7,   8'd9,   8'd1,  8'd1,  8'd1,  54,  0, 1, 30, 0);
        // Start phase equal to the period opens a frame that is still running when the run ends.
        run_phase(8'd5,   8'd5,   8'd2,  8'd3,  8'd1,   0, 54, 1, 20, 100);

        // Poke the running frame: refused write, ignored refresh, unused command.
        queue_item(make_item(CMD_WRITE, 6'd1, 2'd2, 8'h33));
        queue_item(make_item(CMD_REFRESH, 6'd0, 2'd0, 8'd0));
        queue_item(make_item(CMD_BIT + 2'd1, 6'd0, 2'd0, 8'd0));
        repeat (10) queue_item(make_item(CMD_BIT, 6'd0, 2'd0, 8'd0));
        drain();

        run_phase(8'd2,   8'd1,   8'd0,  8'd2,  8'd0,   8,  8, 1, 20, 80);
        // Widest bit timing for part of a bit, then back to the fastest setting.
        run_phase(8'd255, 8'd254, 8'd63, 8'd63, 8'd63, 54,  0, 1, 20, 130);
        run_phase(RST_FRAME_PERIOD, RST_SEND_PHASE, 8'd1, 8'd1, 8'd1, 0, 54, 1, 20, 70);

        repeat (10) @(posedge clk);
        if (status_due.size() != 0)
            report_mismatch("status beats never delivered", 0, status_due.size());

        $display("run covered %0d items and %0d status beats over %0d register writes",
                 items_done, results_seen, reg_writes);
        $display("frames started: %0d, mismatches: %0d", frames_started, mismatches);
        if (mismatches == 0)
            $display("[addressable_led_serializer] OK");
        else
            $display("[addressable_led_serializer] ERROR");
        $finish;
    end

endmodule

// ===== addressable_led_serializer.f =====
+incdir+design
design/ledser_pkg.sv
design/ledser_store.sv
design/ledser_mod.sv
design/ledser_core.sv
design/addressable_led_serializer.sv
dv/tb.sv
